FILE: src/trcm_pkg.sv
// ----------------------------------------------------------------------------
// trcm_pkg
// Shared widths, types, register indexes and arithmetic helpers for the
// triangle reference coordinate map.
// ----------------------------------------------------------------------------
package trcm_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int NUM_W       = SUM_W + FRAC_BITS;
  localparam int NUM_REGS    = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_MUL     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_C0X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C0Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C1X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C1Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C2X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C2Y = 3'd5;

  localparam logic REQ_TO_REF  = 1'b0;
  localparam logic REQ_TO_CART = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic        [SUM_W-1:0]       mag_t;
  typedef logic        [COORD_WIDTH-1:0] quo_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t ONE_FIXED = coord_t'(1) <<< FRAC_BITS;

  typedef struct packed {
    logic val_neg;
    logic ovf;
    mag_t rem;
    quo_t nlow;
    quo_t q;
  } div_lane_t;

  typedef struct packed {
    logic      to_cart;
    logic      degen;
    mag_t      dmag;
    div_lane_t lane0;
    div_lane_t lane1;
    coord_t    res0;
    coord_t    res1;
    logic      rsat;
  } div_t;

  typedef struct packed {
    coord_t val;
    logic   clip;
  } sat_t;

  function automatic sat_t sat_coord(input sum_t v);
    sat_t r;
    r.clip = 1'b1;
    if (v > sum_t'(COORD_MAX)) begin
      r.val = COORD_MAX;
    end else if (v < sum_t'(COORD_MIN)) begin
      r.val = COORD_MIN;
    end else begin
      r.val  = v[COORD_WIDTH-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  function automatic mag_t mag_abs(input sum_t v);
    sum_t n;
    n = -v;
    return v[SUM_W-1] ? mag_t'(n) : mag_t'(v);
  endfunction

  function automatic div_lane_t div_lane_init(input mag_t nmag, input mag_t dmag,
                                              input logic val_neg);
    logic [NUM_W-1:0] nfull;
    logic [NUM_W-1:0] ntop;
    div_lane_t        l;
    nfull     = {nmag, {FRAC_BITS{1'b0}}};
    ntop      = nfull >> COORD_WIDTH;
    l.val_neg = val_neg;
    l.ovf     = ntop >= NUM_W'(dmag);
    l.rem     = ntop[SUM_W-1:0];
    l.nlow    = nfull[COORD_WIDTH-1:0];
    l.q       = '0;
    return l;
  endfunction

  function automatic div_lane_t div_lane_step(input div_lane_t l, input mag_t dmag);
    logic [SUM_W:0] r2;
    logic [SUM_W:0] diff;
    logic           ge;
    div_lane_t      o;
    r2     = {l.rem, l.nlow[COORD_WIDTH-1]};
    diff   = r2 - {1'b0, dmag};
    ge     = r2 >= {1'b0, dmag};
    o      = l;
    o.rem  = ge ? diff[SUM_W-1:0] : r2[SUM_W-1:0];
    o.nlow = l.nlow << 1;
    o.q    = {l.q[COORD_WIDTH-2:0], ge};
    return o;
  endfunction

  function automatic sat_t fin_quo(input div_lane_t l);
    sat_t r;
    quo_t n;
    n      = ~l.q + quo_t'(1);
    r.clip = 1'b1;
    if (l.val_neg) begin
      if (l.ovf || (l.q > quo_t'(COORD_MIN))) begin
        r.val = COORD_MIN;
      end else begin
        r.val  = coord_t'(n);
        r.clip = 1'b0;
      end
    end else begin
      if (l.ovf || l.q[COORD_WIDTH-1]) begin
        r.val = COORD_MAX;
      end else begin
        r.val  = coord_t'(l.q);
        r.clip = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

FILE: src/trcm_if.sv
// ----------------------------------------------------------------------------
// trcm_req_if / trcm_rsp_if
// Valid/ready channels carrying mapping requests and mapping results.
// ----------------------------------------------------------------------------
interface trcm_req_if;
  import trcm_pkg::*;
  logic   valid;
  logic   ready;
  logic   req_type;
  coord_t in_first;
  coord_t in_second;
  modport source(output valid, output req_type, output in_first, output in_second,
                 input ready);
  modport sink(input valid, input req_type, input in_first, input in_second,
               output ready);
endinterface

interface trcm_rsp_if;
  import trcm_pkg::*;
  logic   valid;
  logic   ready;
  coord_t out_first;
  coord_t out_second;
  logic   degenerate;
  logic   saturated;
  modport source(output valid, output out_first, output out_second,
                 output degenerate, output saturated, input ready);
  modport sink(input valid, input out_first, input out_second,
               input degenerate, input saturated, output ready);
endinterface

FILE: src/trcm_div_step.sv
// ----------------------------------------------------------------------------
// trcm_div_step
// One restoring division step for both quotient lanes, one pipeline stage.
// ----------------------------------------------------------------------------
module trcm_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic          valid_in,
  input  trcm_pkg::div_t d_in,
  output logic          valid_out,
  output trcm_pkg::div_t d_out
);
  import trcm_pkg::*;

  div_t d_next;

  always_comb begin
    d_next       = d_in;
    d_next.lane0 = div_lane_step(d_in.lane0, d_in.dmag);
    d_next.lane1 = div_lane_step(d_in.lane1, d_in.dmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (load) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_out <= d_next;
    end
  end

endmodule

FILE: src/triangle_reference_coordinate_map.sv
// ----------------------------------------------------------------------------
// triangle_reference_coordinate_map
// Maps Q16.16 points between Cartesian space and a triangle's (u,v) frame.
// ----------------------------------------------------------------------------
// One item enters per clock while the pipeline is not stalled, and passes
// through the differences, multiplication, summing, sign and magnitude
// set-up, the restoring divider stages, each adding a quotient bit, and the
// output register.
// The divider chain sets the latency. Bubbles are squeezed out on a stall, so
// the input keeps taking items while any stage is free. The user must write
// corner registers only while no item is in flight; the block does not enforce it.
module triangle_reference_coordinate_map (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [trcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trcm_pkg::COORD_WIDTH-1:0] cfg_data,
  trcm_req_if.sink                         req,
  trcm_rsp_if.source                       rsp
);
  import trcm_pkg::*;

  coord_t vert_x [3];
  coord_t vert_y [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vert_x[0] <= '0;
      vert_y[0] <= '0;
      vert_x[1] <= ONE_FIXED;
      vert_y[1] <= '0;
      vert_x[2] <= '0;
      vert_y[2] <= ONE_FIXED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_C0X: vert_x[0] <= cfg_data;
        REG_C0Y: vert_y[0] <= cfg_data;
        REG_C1X: vert_x[1] <= cfg_data;
        REG_C1Y: vert_y[1] <= cfg_data;
        REG_C2X: vert_x[2] <= cfg_data;
        REG_C2Y: vert_y[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                   v1, v2, v3, v4, vout;
  logic                   ld1, ld2, ld3, ld4, ld_out;
  logic [COORD_WIDTH-1:0] dv;
  logic [COORD_WIDTH-1:0] ld_div;
  div_t                   dd [COORD_WIDTH];

  assign ld_out                = !vout || rsp.ready;
  assign ld_div[COORD_WIDTH-1] = !dv[COORD_WIDTH-1] || ld_out;
  for (genvar k = 0; k < COORD_WIDTH - 1; k++) begin : g_ld
    assign ld_div[k] = !dv[k] || ld_div[k+1];
  end
  assign ld4       = !v4 || ld_div[0];
  assign ld3       = !v3 || ld4;
  assign ld2       = !v2 || ld3;
  assign ld1       = !v1 || ld2;
  assign req.ready = ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      vout <= 1'b0;
    end else begin
      if (ld1)    v1   <= req.valid;
      if (ld2)    v2   <= v1;
      if (ld3)    v3   <= v2;
      if (ld4)    v4   <= v3;
      if (ld_out) vout <= dv[COORD_WIDTH-1];
    end
  end

  // Differences: pick multiplier operands per request type
  diff_t  ma_next [NUM_MUL];
  diff_t  mb_next [NUM_MUL];
  diff_t  s1_ma   [NUM_MUL];
  diff_t  s1_mb   [NUM_MUL];
  logic   s1_to_cart;
  coord_t s1_bx, s1_by;

  always_comb begin
    diff_t ax, by, x0, y0, x1, y1, x2, y2;
    ax = diff_t'(req.in_first);
    by = diff_t'(req.in_second);
    x0 = diff_t'(vert_x[0]);
    y0 = diff_t'(vert_y[0]);
    x1 = diff_t'(vert_x[1]);
    y1 = diff_t'(vert_y[1]);
    x2 = diff_t'(vert_x[2]);
    y2 = diff_t'(vert_y[2]);
    if (req.req_type == REQ_TO_CART) begin
      ma_next[0] = x1 - x0;  mb_next[0] = ax;
      ma_next[1] = x2 - x0;  mb_next[1] = by;
      ma_next[2] = y1 - y0;  mb_next[2] = ax;
      ma_next[3] = y2 - y0;  mb_next[3] = by;
      ma_next[4] = '0;       mb_next[4] = '0;
      ma_next[5] = '0;       mb_next[5] = '0;
    end else begin
      ma_next[0] = x0 - ax;  mb_next[0] = y2 - by;
      ma_next[1] = x2 - ax;  mb_next[1] = y0 - by;
      ma_next[2] = x0 - ax;  mb_next[2] = y1 - by;
      ma_next[3] = x1 - ax;  mb_next[3] = y0 - by;
      ma_next[4] = x0 - x1;  mb_next[4] = y2 - y1;
      ma_next[5] = x2 - x1;  mb_next[5] = y0 - y1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_ma      <= ma_next;
      s1_mb      <= mb_next;
      s1_to_cart <= req.req_type;
      s1_bx      <= vert_x[0];
      s1_by      <= vert_y[0];
    end
  end

  // Products
  prod_t  s2_p [NUM_MUL];
  logic   s2_to_cart;
  coord_t s2_bx, s2_by;

  always_ff @(posedge clk) begin
    if (ld2) begin
      for (int i = 0; i < NUM_MUL; i++) begin
        s2_p[i] <= s1_ma[i] * s1_mb[i];
      end
      s2_to_cart <= s1_to_cart;
      s2_bx      <= s1_bx;
      s2_by      <= s1_by;
    end
  end

  // Sums: numerators and determinant, or affine sums
  sum_t s3_s0, s3_s1, s3_s2;
  logic s3_to_cart;

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_to_cart <= s2_to_cart;
      if (s2_to_cart == REQ_TO_CART) begin
        s3_s0 <= (sum_t'(s2_bx) <<< FRAC_BITS) + sum_t'(s2_p[0]) + sum_t'(s2_p[1]);
        s3_s1 <= (sum_t'(s2_by) <<< FRAC_BITS) + sum_t'(s2_p[2]) + sum_t'(s2_p[3]);
        s3_s2 <= '0;
      end else begin
        s3_s0 <= sum_t'(s2_p[0]) - sum_t'(s2_p[1]);
        s3_s1 <= sum_t'(s2_p[2]) - sum_t'(s2_p[3]);
        s3_s2 <= sum_t'(s2_p[4]) - sum_t'(s2_p[5]);
      end
    end
  end

  // Sign, magnitude and divider set-up; affine results finish here
  div_t s4_next, s4;

  always_comb begin
    sat_t r0, r1;
    mag_t dmag;
    r0              = sat_coord(s3_s0 >>> FRAC_BITS);
    r1              = sat_coord(s3_s1 >>> FRAC_BITS);
    dmag            = mag_abs(s3_s2);
    s4_next.to_cart = s3_to_cart;
    s4_next.degen   = (s3_to_cart == REQ_TO_REF) && (s3_s2 == '0);
    s4_next.dmag    = dmag;
    s4_next.lane0   = div_lane_init(mag_abs(s3_s0), dmag,
                                    s3_s0[SUM_W-1] ^ s3_s2[SUM_W-1]);
    s4_next.lane1   = div_lane_init(mag_abs(s3_s1), dmag,
                                    s3_s1[SUM_W-1] ^ ~s3_s2[SUM_W-1]);
    s4_next.res0    = r0.val;
    s4_next.res1    = r1.val;
    s4_next.rsat    = r0.clip || r1.clip;
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4 <= s4_next;
    end
  end

  for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_div
    if (k == 0) begin : g_first
      trcm_div_step u_step (
        .clk(clk), .rst(rst), .load(ld_div[k]),
        .valid_in(v4), .d_in(s4),
        .valid_out(dv[k]), .d_out(dd[k])
      );
    end else begin : g_rest
      trcm_div_step u_step (
        .clk(clk), .rst(rst), .load(ld_div[k]),
        .valid_in(dv[k-1]), .d_in(dd[k-1]),
        .valid_out(dv[k]), .d_out(dd[k])
      );
    end
  end

  // Final selection into the output register
  coord_t o_first, o_second;
  logic   o_degen, o_sat;

  always_comb begin
    div_t d;
    sat_t q0, q1;
    d  = dd[COORD_WIDTH-1];
    q0 = fin_quo(d.lane0);
    q1 = fin_quo(d.lane1);
    if (d.to_cart == REQ_TO_CART) begin
      o_first  = d.res0;
      o_second = d.res1;
      o_degen  = 1'b0;
      o_sat    = d.rsat;
    end else if (d.degen) begin
      o_first  = '0;
      o_second = '0;
      o_degen  = 1'b1;
      o_sat    = 1'b0;
    end else begin
      o_first  = q0.val;
      o_second = q1.val;
      o_degen  = 1'b0;
      o_sat    = q0.clip || q1.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      rsp.out_first  <= o_first;
      rsp.out_second <= o_second;
      rsp.degenerate <= o_degen;
      rsp.saturated  <= o_sat;
    end
  end

  assign rsp.valid = vout;

endmodule

FILE: src/trcm_checker.sv
// ----------------------------------------------------------------------------
// trcm_checker
// Port-level checks on the coordinate map, attached to the top level by bind.
// ----------------------------------------------------------------------------
module trcm_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_ready,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic [trcm_pkg::COORD_WIDTH-1:0] out_first,
  input logic [trcm_pkg::COORD_WIDTH-1:0] out_second,
  input logic                             degenerate,
  input logic                             saturated
);
  import trcm_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && degenerate |-> out_first == '0 && out_second == '0 && !saturated)
    else $error("degenerate result not zeroed");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("input stalled while output free");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_first) && $stable(out_second)
      && $stable(degenerate) && $stable(saturated))
    else $error("stalled result changed");

endmodule

bind triangle_reference_coordinate_map trcm_checker u_trcm_checker (
  .clk(clk),
  .rst(rst),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .out_first(rsp.out_first),
  .out_second(rsp.out_second),
  .degenerate(rsp.degenerate),
  .saturated(rsp.saturated)
);

FILE: sim/triangle_reference_coordinate_map_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_reference_coordinate_map_test
// Self-checking bench for the triangle reference coordinate map. A driver
// pushes mapping requests from a queue, predicts each mapped point with exact
// wide arithmetic, and a monitor compares every result transfer in order.
// Corner settings change between phases, covering default, extreme,
// degenerate and random triangles, with random idling on both channels outside the extreme phase.
// ----------------------------------------------------------------------------
module triangle_reference_coordinate_map_test;
  import trcm_pkg::*;

  localparam int  DRAIN_CYCLES = 45;
  localparam int  CYCLE_LIMIT  = 600000;
  localparam int  RAND_PER_SET = 300;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic   kind;
    coord_t a;
    coord_t b;
  } map_req_t;

  typedef struct {
    coord_t first;
    coord_t second;
    logic   degen;
    logic   sat;
  } map_rsp_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_WIDTH-1:0] cfg_data;

  trcm_req_if req_ch();
  trcm_rsp_if rsp_ch();

  triangle_reference_coordinate_map dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  coord_t   corner [NUM_REGS];
  map_req_t pending_reqs[$];
  map_rsp_t expected_maps[$];
  logic     hold_send;
  logic     idle_en;
  int       errors;
  int       cycles;
  int       n_checked;
  int       n_degen;
  int       n_sat;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic wide_t det_unit(wide_t ax, wide_t ay, wide_t bx, wide_t by,
                                     wide_t cx, wide_t cy);
    return (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
  endfunction

  function automatic coord_t clamp(wide_t v, inout logic clip);
    if (v > wide_t'(COORD_MAX)) begin
      clip = 1'b1;
      return COORD_MAX;
    end else if (v < wide_t'(COORD_MIN)) begin
      clip = 1'b1;
      return COORD_MIN;
    end
    return coord_t'(v);
  endfunction

  function automatic map_rsp_t map_point(map_req_t r);
    wide_t    x0, y0, x1, y1, x2, y2, a, b, du, dv, nu, nv, sx, sy;
    map_rsp_t o;
    logic     clip;
    x0 = corner[REG_C0X]; y0 = corner[REG_C0Y];
    x1 = corner[REG_C1X]; y1 = corner[REG_C1Y];
    x2 = corner[REG_C2X]; y2 = corner[REG_C2Y];
    a = r.a;
    b = r.b;
    clip = 1'b0;
    o.degen = 1'b0;
    if (r.kind == REQ_TO_REF) begin
      du = det_unit(x1, y1, x0, y0, x2, y2);
      dv = det_unit(x2, y2, x0, y0, x1, y1);
      if (du == 0) begin
        o.first = '0;
        o.second = '0;
        o.degen = 1'b1;
      end else begin
        nu = det_unit(a, b, x0, y0, x2, y2);
        nv = det_unit(a, b, x0, y0, x1, y1);
        o.first  = clamp((nu <<< FRAC_BITS) / du, clip);
        o.second = clamp((nv <<< FRAC_BITS) / dv, clip);
      end
    end else begin
      sx = (x0 <<< FRAC_BITS) + (x1 - x0) * a + (x2 - x0) * b;
      sy = (y0 <<< FRAC_BITS) + (y1 - y0) * a + (y2 - y0) * b;
      o.first  = clamp(sx >>> FRAC_BITS, clip);
      o.second = clamp(sy >>> FRAC_BITS, clip);
    end
    o.sat = clip;
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    map_req_t nxt;
    if (rst) begin
      req_ch.valid     <= 1'b0;
      req_ch.req_type  <= REQ_TO_REF;
      req_ch.in_first  <= '0;
      req_ch.in_second <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        nxt.kind = req_ch.req_type;
        nxt.a    = req_ch.in_first;
        nxt.b    = req_ch.in_second;
        expected_maps.insert(expected_maps.size(), map_point(nxt));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() > 0 && !hold_send &&
            !(idle_en && $urandom_range(99) < 15)) begin
          nxt = pending_reqs.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.req_type  <= nxt.kind;
          req_ch.in_first  <= nxt.a;
          req_ch.in_second <= nxt.b;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    map_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_maps.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer first=%h second=%h", $time,
                   rsp_ch.out_first, rsp_ch.out_second);
        end else begin
          want = expected_maps.pop_front();
          n_checked++;
          if (want.degen) n_degen++;
          if (want.sat) n_sat++;
          if (rsp_ch.out_first !== want.first) begin
            errors++;
            $display("%0t: out_first expected %h actual %h", $time, want.first,
                     rsp_ch.out_first);
          end
          if (rsp_ch.out_second !== want.second) begin
            errors++;
            $display("%0t: out_second expected %h actual %h", $time, want.second,
                     rsp_ch.out_second);
          end
          if (rsp_ch.degenerate !== want.degen) begin
            errors++;
            $display("%0t: degenerate expected %b actual %b", $time, want.degen,
                     rsp_ch.degenerate);
          end
          if (rsp_ch.saturated !== want.sat) begin
            errors++;
            $display("%0t: saturated expected %b actual %b", $time, want.sat,
                     rsp_ch.saturated);
          end
        end
      end
      rsp_ch.ready <= idle_en ? ($urandom_range(99) >= 15) : 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d transfers outstanding", $time,
               expected_maps.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_corner(logic [CFG_IDX_W-1:0] idx, coord_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    corner[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_triangle(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                              coord_t x2, coord_t y2);
    write_corner(REG_C0X, x0);
    write_corner(REG_C0Y, y0);
    write_corner(REG_C1X, x1);
    write_corner(REG_C1Y, y1);
    write_corner(REG_C2X, x2);
    write_corner(REG_C2Y, y2);
  endtask

  task automatic push(logic kind, coord_t a, coord_t b);
    map_req_t r;
    r.kind = kind;
    r.a    = a;
    r.b    = b;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  function automatic coord_t any_coord();
    case ($urandom_range(5))
      0, 1: return coord_t'($urandom);
      2:    return coord_t'($signed($urandom_range(1 << 18)) - (1 << 17));
      3:    return coord_t'($signed($urandom_range(1 << 22)) - (1 << 21));
      4:    return coord_t'($signed($urandom_range(1 << 12)) - (1 << 11));
      default: begin
        case ($urandom_range(3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return ONE_FIXED;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || req_ch.valid) @(posedge clk);
    while (expected_maps.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_batch(int n);
    for (int i = 0; i < n; i++) push(1'($urandom_range(1)), any_coord(), any_coord());
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    hold_send = 1'b0;
    idle_en   = 1'b1;
    errors    = 0;
    cycles    = 0;
    n_checked = 0;
    n_degen   = 0;
    n_sat     = 0;
    corner[REG_C0X] = '0;
    corner[REG_C0Y] = '0;
    corner[REG_C1X] = ONE_FIXED;
    corner[REG_C1Y] = '0;
    corner[REG_C2X] = '0;
    corner[REG_C2Y] = ONE_FIXED;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset triangle, directed edges of both directions
    push(REQ_TO_REF, '0, '0);
    push(REQ_TO_REF, ONE_FIXED, '0);
    push(REQ_TO_REF, '0, ONE_FIXED);
    push(REQ_TO_REF, COORD_MAX, COORD_MAX);
    push(REQ_TO_REF, COORD_MIN, COORD_MIN);
    push(REQ_TO_REF, COORD_MAX, COORD_MIN);
    push(REQ_TO_REF, -32'sd1, 32'sd1);
    push(REQ_TO_CART, '0, '0);
    push(REQ_TO_CART, ONE_FIXED, ONE_FIXED);
    push(REQ_TO_CART, COORD_MAX, COORD_MIN);
    push(REQ_TO_CART, COORD_MIN, COORD_MIN);
    push(REQ_TO_CART, -32'sd1, -32'sd1);
    random_batch(RAND_PER_SET);
    drain();

    // hold the sender mid-stream until the pipe is empty
    random_batch(20);
    repeat (10) @(posedge clk);
    hold_send = 1'b1;
    while (expected_maps.size() > 0 || req_ch.valid) @(posedge clk);
    hold_send = 1'b0;
    drain();

    // extreme corners, no idling in this phase
    idle_en = 1'b0;
    set_triangle(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    push(REQ_TO_REF, COORD_MAX, COORD_MAX);
    push(REQ_TO_REF, COORD_MIN, COORD_MAX);
    push(REQ_TO_CART, COORD_MAX, COORD_MAX);
    push(REQ_TO_CART, COORD_MIN, COORD_MIN);
    random_batch(RAND_PER_SET);
    drain();
    idle_en = 1'b1;

    // collinear corners: degenerate
    set_triangle('0, '0, ONE_FIXED, ONE_FIXED, 32'sh0002_0000, 32'sh0002_0000);
    push(REQ_TO_REF, ONE_FIXED, '0);
    push(REQ_TO_CART, ONE_FIXED, ONE_FIXED);
    random_batch(150);
    drain();
    set_triangle('0, '0, '0, '0, '0, '0);
    random_batch(100);
    drain();

    // random triangles
    for (int s = 0; s < 4; s++) begin
      if (s == 0)
        set_triangle(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
      else
        set_triangle(any_coord(), any_coord(), any_coord(), any_coord(),
                     any_coord(), any_coord());
      random_batch(RAND_PER_SET - 50);
      drain();
    end

    $display("Checked %0d mapped points over default, extreme, degenerate and", n_checked);
    $display("random triangles; %0d degenerate, %0d clipped.", n_degen, n_sat);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
